[rtl/core/hbpwm_pkg.sv]
// Shared types and constants for the H-bridge PWM and beep driver.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package hbpwm_pkg;

   // Input command codes (req_tuser)
   localparam logic [2:0] MODE_TICK = 3'd0;
   localparam logic [2:0] MODE_FWD  = 3'd1;
   localparam logic [2:0] MODE_BWD  = 3'd2;
   localparam logic [2:0] MODE_BEEP = 3'd3;
   localparam logic [2:0] MODE_STOP = 3'd4;

   // Activity codes
   localparam logic [1:0] ACT_STOP = 2'd0;
   localparam logic [1:0] ACT_FWD  = 2'd1;
   localparam logic [1:0] ACT_BWD  = 2'd2;
   localparam logic [1:0] ACT_BEEP = 2'd3;

   // Beep time base and divider sizing
   localparam int unsigned BEEP_CLOCK_HZ = 1000000;
   localparam int unsigned DIV_STEPS     = 20;
   localparam int unsigned DIV_CNT_W     = 5;

   // CSR register indexes
   localparam logic [1:0] REG_RUN_PSC  = 2'd0;
   localparam logic [1:0] REG_BEEP_PSC = 2'd1;
   localparam logic [1:0] REG_DEADBAND = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   typedef struct packed {
      logic item_load;   // single-cycle transaction takes effect
      logic div_start;   // beep accepted, load divider
      logic div_step;    // one quotient bit
      logic div_commit;  // apply beep period and emit result
   } cmd_type;

   typedef struct packed {
      logic long_cmd;    // pending input is a beep that needs the divider
      logic div_last;    // final quotient bit this cycle
      logic out_free;    // result register can take a new value
   } status_type;

   typedef struct packed {
      logic [15:0] run_psc;
      logic [15:0] beep_psc;
      logic [15:0] deadband;
   } cfg_type;

endpackage

[rtl/core/hbridge_pwm_and_beep_driver.sv]
// H-bridge PWM and beep driver, top level: CSR block, controller, datapath.
// Tick, run and stop transactions: result registered in the cycle after acceptance,
// one per cycle while the receiver keeps up. Beep transaction: result registered
// after the 20-step bit-serial period divider; input is held off until it is out.
// Synchronous active-high reset: bridge stopped, counters and CSRs cleared.
// Depends on hbpwm_pkg, hbpwm_ctrl, hbpwm_datapath.
`timescale 1ns / 1ps

module hbridge_pwm_and_beep_driver #(
   parameter int unsigned DUTY_BITS = 10   // PWM resolution, 4..16
) (
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [15:0] level, [35:16] freq, [39:36] zero
   input  logic [2:0]  req_tuser,   // [2:0] mode
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] leg_a, [1] leg_b, [3:2] activity, [7:4] zero
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hbpwm_pkg::*;

   logic [15:0] run_psc_ff;
   logic [15:0] beep_psc_ff;
   logic [15:0] deadband_ff;
   logic        csr_wr;
   cfg_type     cfg;
   cmd_type     cmd;
   status_type  sts;
   logic        leg_a, leg_b;
   logic [1:0]  activity;

   // ---------------- CSR block ----------------
   // Registers sit at byte offsets 0, 4, 8; writes land on the access phase.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_psc_ff  <= '0;
         beep_psc_ff <= '0;
         deadband_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_RUN_PSC:  run_psc_ff  <= csr_pwdata[15:0];
            REG_BEEP_PSC: beep_psc_ff <= csr_pwdata[15:0];
            REG_DEADBAND: deadband_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_RUN_PSC:  csr_prdata = {16'd0, run_psc_ff};
         REG_BEEP_PSC: csr_prdata = {16'd0, beep_psc_ff};
         REG_DEADBAND: csr_prdata = {16'd0, deadband_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.run_psc  = run_psc_ff;
   assign cfg.beep_psc = beep_psc_ff;
   assign cfg.deadband = deadband_ff;

   // ---------------- controller ----------------
   // Accepts a transaction when idle and the result register is empty or
   // draining; beeps with a frequency of 2 or more divert into the divide sequence.
   hbpwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // ---------------- datapath ----------------
   // Holds mode, compare, top and both counters, the beep period divider
   // and the registered result.
   hbpwm_datapath #(
      .DUTY_BITS (DUTY_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_mode     (req_tuser),
      .req_level    (req_tdata[15:0]),
      .req_freq     (req_tdata[35:16]),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_leg_a    (leg_a),
      .rsp_leg_b    (leg_b),
      .rsp_activity (activity)
   );

   assign rsp_tdata = {4'd0, activity, leg_b, leg_a};

endmodule

[rtl/core/hbpwm_ctrl.sv]
// Controller FSM: sequences single-cycle transactions and the beep divide.
// Depends on hbpwm_pkg.
`timescale 1ns / 1ps

module hbpwm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  hbpwm_pkg::status_type sts,
   output hbpwm_pkg::cmd_type    cmd
);
   import hbpwm_pkg::*;

   state_type state_ff, state_in;
   logic      fire;

   assign req_tready = (state_ff == S_IDLE) && sts.out_free;
   assign fire       = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               if (sts.long_cmd) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end else begin
                  cmd.item_load = 1'b1;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.div_commit = 1'b1;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[rtl/core/hbpwm_datapath.sv]
// Datapath: PWM counters, mode state, beep period divider, result register.
// Depends on hbpwm_pkg.
`timescale 1ns / 1ps

module hbpwm_datapath #(
   parameter int unsigned DUTY_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hbpwm_pkg::cfg_type     cfg,
   input  logic [2:0]            req_mode,
   input  logic [15:0]           req_level,
   input  logic [19:0]           req_freq,
   input  hbpwm_pkg::cmd_type     cmd,
   output hbpwm_pkg::status_type  sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_leg_a,
   output logic                  rsp_leg_b,
   output logic [1:0]            rsp_activity
);
   import hbpwm_pkg::*;

   localparam logic [16:0] FULL    = 17'd1 << DUTY_BITS;
   localparam logic [15:0] RUN_TOP = 16'(FULL - 17'd1);

   // architectural state
   logic [1:0]  mode_ff,  mode_in;
   logic [15:0] cmp_ff,   cmp_in;
   logic [15:0] top_ff,   top_in;
   logic [15:0] per_ff,   per_in;
   logic [15:0] psc_ff,   psc_in;

   // divider
   logic [18:0]          rem_ff, rem_in;
   logic [19:0]          dvd_ff, dvd_in;
   logic [18:0]          dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [19:0]          shifted;
   logic [20:0]          diff;
   logic [19:0]          q_minus;
   logic [15:0]          beep_top;

   // result register
   logic       vld_ff, vld_in;
   logic       a_ff, a_in, b_ff, b_in;
   logic [1:0] act_ff;

   logic [15:0] psc_sel;
   logic        below;

   assign sts.long_cmd = (req_mode == MODE_BEEP) && (req_freq[19:1] != 19'd0);
   assign sts.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign sts.out_free = !vld_ff || rsp_tready;

   // restoring divide, one quotient bit per cycle
   assign shifted  = {rem_ff, dvd_ff[19]};
   assign diff     = {1'b0, shifted} - {2'b00, dsr_ff};
   assign q_minus  = dvd_ff - 20'd1;
   assign beep_top = (q_minus[19:16] != 4'd0) ? 16'hFFFF : q_minus[15:0];

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         dvd_in = 20'(BEEP_CLOCK_HZ);
         dsr_in = req_freq[19:1];
         cnt_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (!diff[20]) begin
            rem_in = diff[18:0];
            dvd_in = {dvd_ff[18:0], 1'b1};
         end else begin
            rem_in = shifted[18:0];
            dvd_in = {dvd_ff[18:0], 1'b0};
         end
      end
   end

   assign psc_sel = (mode_ff == ACT_BEEP) ? cfg.beep_psc : cfg.run_psc;

   always_comb begin
      mode_in = mode_ff;
      cmp_in  = cmp_ff;
      top_in  = top_ff;
      per_in  = per_ff;
      psc_in  = psc_ff;
      if (cmd.item_load) begin
         case (req_mode)
            MODE_TICK: begin
               if (mode_ff != ACT_STOP) begin
                  if (psc_ff >= psc_sel) begin
                     psc_in = '0;
                     per_in = (per_ff >= top_ff) ? 16'd0 : per_ff + 16'd1;
                  end else begin
                     psc_in = psc_ff + 16'd1;
                  end
               end
            end
            MODE_FWD, MODE_BWD: begin
               if (req_level < cfg.deadband) begin
                  mode_in = ACT_STOP;
                  per_in  = '0;
                  psc_in  = '0;
               end else if ({1'b0, req_level} < FULL) begin
                  mode_in = (req_mode == MODE_FWD) ? ACT_FWD : ACT_BWD;
                  top_in  = RUN_TOP;
                  cmp_in  = req_level;
                  per_in  = '0;
                  psc_in  = '0;
               end
            end
            MODE_BEEP, MODE_STOP: begin
               // a beep reaching here has a frequency of 0 or 1
               mode_in = ACT_STOP;
               per_in  = '0;
               psc_in  = '0;
            end
            default: ;
         endcase
      end else if (cmd.div_commit) begin
         mode_in = ACT_BEEP;
         top_in  = beep_top;
         cmp_in  = {1'b0, beep_top[15:1]};
         per_in  = '0;
         psc_in  = '0;
      end
   end

   // leg levels from the post-update state
   assign below = per_in < cmp_in;

   always_comb begin
      a_in = 1'b0;
      b_in = 1'b0;
      case (mode_in)
         ACT_FWD:  a_in = below;
         ACT_BWD:  b_in = below;
         ACT_BEEP: begin
            a_in = below;
            b_in = !below;
         end
         default: ;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.item_load || cmd.div_commit) vld_in = 1'b1;
      else if (rsp_tready)                 vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ACT_STOP;
         cmp_ff  <= '0;
         top_ff  <= '0;
         per_ff  <= '0;
         psc_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         cmp_ff  <= cmp_in;
         top_ff  <= top_in;
         per_ff  <= per_in;
         psc_ff  <= psc_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (cmd.item_load || cmd.div_commit) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         act_ff <= mode_in;
      end
   end

   assign rsp_tvalid   = vld_ff;
   assign rsp_leg_a    = a_ff;
   assign rsp_leg_b    = b_ff;
   assign rsp_activity = act_ff;

endmodule

[sim/hbridge_pwm_and_beep_driver_tb.sv]
// Self-checking testbench for the H-bridge PWM and beep driver.
// Depends on hbpwm_pkg and hbridge_pwm_and_beep_driver, which pulls in hbpwm_ctrl and hbpwm_datapath.
`timescale 1ns / 1ps

module hbridge_pwm_and_beep_driver_tb;
   import hbpwm_pkg::*;

   localparam int unsigned DUTY_BITS   = 10;
   localparam int unsigned DUTY_FULL   = 32'd1 << DUTY_BITS;   // first oversized level
   localparam int unsigned CYCLE_LIMIT = 500000;               // watchdog, many times a slow run
   localparam int unsigned SETTLE      = 40;                   // longer than a beep divide
   localparam int unsigned LONG_HOLD   = 300;                  // receiver hold-off for pressure

   // one result transaction, unpacked from rsp_tdata
   typedef struct packed {
      logic [1:0] activity;
      logic       leg_b;
      logic       leg_a;
   } legs_type;

   // ------------------------------------------------------------------
   // Scoreboard: own copy of the bridge state and CSRs, predicts the leg
   // levels for each accepted command, checks results in order.
   // ------------------------------------------------------------------
   class leg_scoreboard;
      logic [15:0] run_psc, beep_psc, deadband;
      logic [1:0]  active;
      logic [15:0] cmp_val, top_val, period_cnt, psc_cnt;
      legs_type    expected_legs[$];
      int unsigned errors;

      function new();
         run_psc = '0; beep_psc = '0; deadband = '0;
         active = ACT_STOP;
         cmp_val = '0; top_val = '0; period_cnt = '0; psc_cnt = '0;
         errors = 0;
      endfunction

      function int unsigned pending();
         return expected_legs.size();
      endfunction

      function void set_register(logic [1:0] idx, logic [15:0] value);
         case (idx)
            REG_RUN_PSC:  run_psc  = value;
            REG_BEEP_PSC: beep_psc = value;
            REG_DEADBAND: deadband = value;
            default: ;
         endcase
      endfunction

      function void halt_bridge();
         active = ACT_STOP;
         period_cnt = '0;
         psc_cnt = '0;
      endfunction

      function void start_run(logic [1:0] dir, logic [15:0] level);
         if (level < deadband) begin
            halt_bridge();   // low level: stop and nothing more
         end else if (32'(level) < DUTY_FULL) begin
            active = dir;
            top_val = 16'(DUTY_FULL - 1);
            cmp_val = level;
            period_cnt = '0;
            psc_cnt = '0;
         end               // oversized level: ignored
      endfunction

      function void start_beep(logic [19:0] freq);
         int unsigned half, quot, top;
         if (freq < 2) begin
            halt_bridge();
            return;
         end
         half = 32'(freq) / 2;
         quot = BEEP_CLOCK_HZ / half;
         top  = (quot == 0) ? 0 : quot - 1;
         if (top > 32'hFFFF) top = 32'hFFFF;
         active = ACT_BEEP;
         top_val = 16'(top);
         cmp_val = 16'(top / 2);
         period_cnt = '0;
         psc_cnt = '0;
      endfunction

      function void advance_tick();
         logic [15:0] psc;
         if (active == ACT_STOP) return;
         psc = (active == ACT_BEEP) ? beep_psc : run_psc;
         if (psc_cnt >= psc) begin
            psc_cnt = '0;
            if (period_cnt >= top_val) period_cnt = '0;
            else period_cnt = period_cnt + 16'd1;
         end else begin
            psc_cnt = psc_cnt + 16'd1;
         end
      endfunction

      // accepted command: update state, queue the leg levels it leaves
      function void note_command(logic [2:0] mode, logic [15:0] level, logic [19:0] freq);
         legs_type exp_legs;
         logic     below;
         case (mode)
            MODE_TICK: advance_tick();
            MODE_FWD:  start_run(ACT_FWD, level);
            MODE_BWD:  start_run(ACT_BWD, level);
            MODE_BEEP: start_beep(freq);
            MODE_STOP: halt_bridge();
            default: ;
         endcase
         below = (period_cnt < cmp_val);
         exp_legs.activity = active;
         exp_legs.leg_a = (active == ACT_FWD || active == ACT_BEEP) ? below : 1'b0;
         exp_legs.leg_b = (active == ACT_BWD) ? below : ((active == ACT_BEEP) ? !below : 1'b0);
         expected_legs.push_back(exp_legs);
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_legs(logic [7:0] data);
         legs_type got, want;
         got = legs_type'(data[3:0]);
         if (expected_legs.size() == 0) begin
            report($sformatf("result 0x%02h with nothing expected", data));
            return;
         end
         want = expected_legs.pop_front();
         if (got.leg_a !== want.leg_a)
            report($sformatf("leg_a %b, expected %b", got.leg_a, want.leg_a));
         if (got.leg_b !== want.leg_b)
            report($sformatf("leg_b %b, expected %b", got.leg_b, want.leg_b));
         if (got.activity !== want.activity)
            report($sformatf("activity %0d, expected %0d", got.activity, want.activity));
      endtask
   endclass

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // [15:0] level, [35:16] freq, [39:36] zero
   logic [2:0]  req_tuser;    // [2:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [0] leg_a, [1] leg_b, [3:2] activity, [7:4] zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hbridge_pwm_and_beep_driver #(
      .DUTY_BITS(DUTY_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   leg_scoreboard sb = new();

   int unsigned tx_idle_pct = 0;    // chance per cycle that the sender holds back
   int unsigned rx_idle_pct = 0;    // chance per cycle that the receiver stalls
   int unsigned hold_epoch = 0;     // bump to request one long receiver hold-off
   int unsigned cycle_count = 0;
   logic [15:0] cur_gap = '0;       // deadband as last programmed, for near-gap levels

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // every input known from time zero
   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= MODE_TICK;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hbridge_pwm_and_beep_driver_tb failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off when requested so the
   // result path backs up and the block has to stall its input.
   int unsigned seen_epoch = 0;
   int unsigned hold_left = 0;
   always @(posedge clock) begin
      if (hold_epoch != seen_epoch) begin
         seen_epoch = hold_epoch;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitor: sampled right at the edge, so values are the ones the DUT saw.
   // Results are checked before the same-edge command is noted; a result can
   // never belong to a command accepted at that very edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_legs(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_command(req_tuser, req_tdata[15:0], req_tdata[35:16]);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            sb.set_register(csr_paddr[3:2], csr_pwdata[15:0]);
      end
   end

   // One command transaction. Leaves tvalid high; the drain, or a hold-back in
   // the next call, lowers it, so it is never dropped and raised in one step.
   task automatic send_item(logic [2:0] mode, logic [15:0] level, logic [19:0] freq);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, freq, level};
      do @(posedge clock); while (!req_tready);
   endtask

   // Ticks carry random junk in the unused data bits.
   task automatic send_ticks(int unsigned count);
      repeat (count) send_item(MODE_TICK, 16'($urandom), 20'($urandom));
   endtask

   // Wait for every expected result, then let the beep divider settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write then read-back of one CSR; only done with the bridge idle.
   task automatic csr_write_check(logic [1:0] idx, logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== value)
         sb.report($sformatf("CSR %0d read 0x%04h, wrote 0x%04h", idx, csr_prdata[15:0], value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_bridge(logic [15:0] run_psc, logic [15:0] beep_psc, logic [15:0] gap);
      drain();
      csr_write_check(REG_RUN_PSC, run_psc);
      csr_write_check(REG_BEEP_PSC, beep_psc);
      csr_write_check(REG_DEADBAND, gap);
      cur_gap = gap;
   endtask

   // Edge cases at reset settings (all prescales and deadband zero).
   task automatic directed_cases();
      send_ticks(1);                                       // tick while stopped
      send_item(MODE_STOP, 16'($urandom), 20'($urandom));
      send_item(MODE_FWD, 16'd0, 20'($urandom));           // zero duty, legs stay low
      send_ticks(1);
      send_item(MODE_FWD, 16'(DUTY_FULL - 1), 20'($urandom));   // max duty
      send_ticks(2);
      send_item(MODE_BWD, 16'(DUTY_FULL), 20'($urandom));  // oversized, ignored
      send_item(MODE_BWD, 16'hFFFF, 20'hFFFFF);            // oversized, ignored
      send_item(MODE_BWD, 16'd1, 20'd0);                   // one step of duty
      send_ticks(1);
      send_item(MODE_BEEP, 16'($urandom), 20'd0);          // too low, stops
      send_item(MODE_BEEP, 16'($urandom), 20'd1);          // too low, stops
      send_item(MODE_BEEP, 16'($urandom), 20'd2);          // period saturates
      send_ticks(1);
      send_item(MODE_BEEP, 16'($urandom), 20'hFFFFF);      // top of zero
      send_ticks(1);
      send_item(MODE_BEEP, 16'($urandom), 20'd1000000);
      send_item(MODE_BEEP, 16'($urandom), 20'd400000);     // top 4, compare 2
      send_ticks(4);                                       // runs the period up to its top
      send_item(MODE_STOP + 3'd1, 16'($urandom), 20'($urandom));   // unknown modes
      send_item(MODE_STOP + 3'd2, 16'($urandom), 20'($urandom));
      send_item(MODE_STOP + 3'd3, 16'($urandom), 20'($urandom));
      send_item(MODE_STOP, 16'($urandom), 20'($urandom));
   endtask

   // Random traffic: mostly a command followed by a burst of ticks so the
   // counters actually move; some noise and lone ticks mixed in.
   task automatic random_traffic(int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int          near_gap;
      logic [15:0] lvl;
      logic [19:0] fr;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         lvl  = 16'($urandom);
         fr   = 20'($urandom);
         if (pick < 45) begin
            case ($urandom_range(3))
               0: lvl = 16'($urandom_range(63));
               1: lvl = 16'($urandom_range(DUTY_FULL - 1));
               2: lvl = 16'($urandom_range(32'hFFFF, DUTY_FULL));
               default: begin
                  near_gap = int'(cur_gap) + int'($urandom_range(4)) - 2;
                  if (near_gap < 0) near_gap = 0;
                  if (near_gap > 65535) near_gap = 65535;
                  lvl = 16'(near_gap);
               end
            endcase
            send_item($urandom_range(1) ? MODE_FWD : MODE_BWD, lvl, fr);
         end else if (pick < 70) begin
            case ($urandom_range(3))
               0: fr = 20'($urandom_range(32'hFFFFF, 100000));   // short periods, wraps
               1: fr = 20'($urandom_range(3));
               2: fr = 20'($urandom);
               default: fr = 20'($urandom_range(20000, 20));
            endcase
            send_item(MODE_BEEP, lvl, fr);
         end else if (pick < 80) begin
            send_item(MODE_STOP, lvl, fr);
         end else if (pick < 90) begin
            send_item(MODE_STOP + 3'($urandom_range(3, 1)), lvl, fr);
         end else begin
            send_ticks(1);
         end
         sent++;
         pick = $urandom_range(40);
         send_ticks(pick);
         sent += pick;
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, sender lightly idle, receiver often stalled
      tx_idle_pct = 15;
      rx_idle_pct = 65;
      directed_cases();

      // phase 1: sender rarely idle, receiver mostly stalled
      program_bridge(16'd1, 16'd0, 16'd25);
      random_traffic(170);

      // phase 2: roles swapped
      tx_idle_pct = 65;
      rx_idle_pct = 15;
      program_bridge(16'd0, 16'd2, 16'd0);
      random_traffic(170);

      // phase 3: no idling, beep prescale and deadband at their maximum
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      program_bridge(16'd3, 16'hFFFF, 16'hFFFF);
      random_traffic(60);

      // phase 4: run prescale at maximum; receiver holds off for a long
      // stretch while the sender keeps pushing, so the input stalls
      program_bridge(16'hFFFF, 16'd0, 16'd700);
      hold_epoch++;
      random_traffic(200);

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("hbridge_pwm_and_beep_driver_tb passed");
      end else begin
         $display("hbridge_pwm_and_beep_driver_tb failed");
      end
      $finish;
   end

endmodule
